// ----- src/tpwm_pkg.sv -----
// Shared constants for the three-phase center-aligned PWM timer.
// Holds default parameters, field widths, operation codes and register indexes.
// No dependencies.
`default_nettype none

package tpwm_pkg;

    // Default parameter values.
    localparam int unsigned DUTY_FULL_SCALE = 1000;
    localparam int unsigned COUNTER_BITS    = 16;

    // Smallest effective counter peak.
    localparam int unsigned PERIOD_MIN = 2;

    // Fixed field widths.
    localparam int unsigned DUTY_REQ_W = 16;
    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned DUTY_CFG_W = 10;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Number of phases.
    localparam int unsigned NUM_PHASES = 3;

    // Request operation codes.
    typedef enum logic {
        OP_TICK     = 1'b0,
        OP_SET_DUTY = 1'b1
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_TOP   = 2'd0,
        CFG_DUTY_FLOOR   = 2'd1,
        CFG_DUTY_CEILING = 2'd2,
        CFG_ADC_ENABLE   = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

// ----- src/three_phase_center_aligned_pwm.sv -----
// Top level of the three-phase center-aligned PWM timer.
// Depends on tpwm_pkg for constants, operation codes and register indexes.
`default_nettype none

// The block takes one request in every clock cycle while not stalled and returns
// one result for each, loaded into an output register on acceptance. A tick request
// advances the up/down counter by one; a duty-set request clamps three duty
// requests and stores each one's product with the current effective peak as a
// preload. Phase outputs are worked out by comparing the scaled count against
// these products, so no divider is needed. The input stalls only while a
// finished result waits in the output register and the receiver stalls it;
// while the receiver takes results, the sustained rate is one request per cycle, set by
// the single output register stage. Configuration writes are always accepted.
module three_phase_center_aligned_pwm #(
    parameter int unsigned DUTY_FULL_SCALE = tpwm_pkg::DUTY_FULL_SCALE,
    parameter int unsigned COUNTER_BITS    = tpwm_pkg::COUNTER_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Request channel.
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic                             i_op,
    input  wire logic [tpwm_pkg::DUTY_REQ_W-1:0]  i_duty_a,
    input  wire logic [tpwm_pkg::DUTY_REQ_W-1:0]  i_duty_b,
    input  wire logic [tpwm_pkg::DUTY_REQ_W-1:0]  i_duty_c,
    // Result channel.
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic                                  o_pwm_a,
    output logic                                  o_pwm_b,
    output logic                                  o_pwm_c,
    output logic                                  o_adc_trigger,
    output logic                                  o_update_event,
    output logic [tpwm_pkg::COUNT_W-1:0]          o_count_value,
    output logic                                  o_counting_down,
    // Configuration write channel.
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tpwm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tpwm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int unsigned CB    = COUNTER_BITS;
    localparam int unsigned FS    = DUTY_FULL_SCALE;
    localparam int unsigned NPH   = tpwm_pkg::NUM_PHASES;
    // Peak width: the peak register is 16 bits and the counter may be narrower.
    localparam int unsigned PW    = (CB < tpwm_pkg::PERIOD_W) ? CB : tpwm_pkg::PERIOD_W;
    // A clamped duty never exceeds the larger of full scale and a 10-bit register.
    localparam int unsigned DMAX  = (FS > 1023) ? FS : 1023;
    localparam int unsigned DW    = $clog2(DMAX + 1);
    localparam int unsigned FSW   = $clog2(FS + 1);
    localparam int unsigned PRODW = DW + PW;
    localparam int unsigned SCLW  = CB + 1 + FSW;
    localparam int unsigned CMPW  = (SCLW > PRODW) ? SCLW : PRODW;

    localparam logic [CB-1:0] CNT_MAX = '1;
    localparam logic [tpwm_pkg::PERIOD_W-1:0] PEAK_LIMIT =
        tpwm_pkg::PERIOD_W'((64'd1 << PW) - 64'd1);
    localparam logic [tpwm_pkg::PERIOD_W-1:0] PEAK_MIN =
        tpwm_pkg::PERIOD_W'(tpwm_pkg::PERIOD_MIN);

    // Configuration registers.
    logic [tpwm_pkg::PERIOD_W-1:0]   r_period_top;
    logic [tpwm_pkg::DUTY_CFG_W-1:0] r_duty_floor;
    logic [tpwm_pkg::DUTY_CFG_W-1:0] r_duty_ceiling;
    logic                            r_adc_enable;

    // Timer state. Compares are kept as duty times peak, scaled by full scale.
    logic [CB-1:0]    r_counter;
    logic             r_dir_down;
    logic [PRODW-1:0] r_preload [NPH];
    logic [PRODW-1:0] r_active  [NPH];

    // Output register.
    logic                         r_valid;
    logic [NPH-1:0]               r_pwm;
    logic                         r_adc;
    logic                         r_upd;
    logic [tpwm_pkg::COUNT_W-1:0] r_count;
    logic                         r_down;

    // Next values.
    logic [CB-1:0]    n_counter;
    logic             n_dir_down;
    logic             n_turn;
    logic             n_adc;
    logic [PRODW-1:0] n_preload [NPH];
    logic [PRODW-1:0] n_active  [NPH];
    logic [NPH-1:0]   n_pwm;

    logic                          in_accept;
    logic [tpwm_pkg::PERIOD_W-1:0] peak_raw;
    logic [PW-1:0]                 peak;
    logic [CB:0]                   count_inc;
    logic [CMPW-1:0]               count_scaled;
    logic [tpwm_pkg::DUTY_REQ_W-1:0] duty_req [NPH];

    // Saturate a duty request at full scale and clamp nonzero ones into range.
    function automatic logic [DW-1:0] clamp_duty(
        input logic [tpwm_pkg::DUTY_REQ_W-1:0] req,
        input logic [tpwm_pkg::DUTY_CFG_W-1:0] floor_d,
        input logic [tpwm_pkg::DUTY_CFG_W-1:0] ceil_d
    );
        logic [DW-1:0] d;
        d = (req > tpwm_pkg::DUTY_REQ_W'(FS)) ? DW'(FS) : DW'(req);
        if (d != '0) begin
            if (d < DW'(floor_d)) begin
                d = DW'(floor_d);
            end else if (d > DW'(ceil_d)) begin
                d = DW'(ceil_d);
            end
        end
        return d;
    endfunction

    // True when the request is a timer tick.
    function automatic logic op_is_tick(input logic op);
        return tpwm_pkg::t_op'(op) == tpwm_pkg::OP_TICK;
    endfunction

    // A request is taken unless a result is waiting and stalled.
    assign o_stall     = r_valid && i_stall;
    assign in_accept   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign duty_req[0] = i_duty_a;
    assign duty_req[1] = i_duty_b;
    assign duty_req[2] = i_duty_c;

    // Effective peak: raised to the minimum and limited to the counter range.
    always_comb begin
        peak_raw = r_period_top;
        if (peak_raw < PEAK_MIN) begin
            peak_raw = PEAK_MIN;
        end
        if (peak_raw > PEAK_LIMIT) begin
            peak_raw = PEAK_LIMIT;
        end
        peak = PW'(peak_raw);
    end

    // Counter step, turn detection and preload handling.
    always_comb begin
        n_counter  = r_counter;
        n_dir_down = r_dir_down;
        n_turn     = 1'b0;
        n_adc      = 1'b0;
        count_inc  = {1'b0, r_counter} + 1'b1;
        for (int k = 0; k < NPH; k++) begin
            n_preload[k] = PRODW'(clamp_duty(duty_req[k], r_duty_floor, r_duty_ceiling))
                         * PRODW'(peak);
            n_active[k]  = r_active[k];
        end
        if (op_is_tick(i_op)) begin
            if (!r_dir_down) begin
                if (count_inc >= (CB + 1)'(peak)) begin
                    n_counter = CB'(peak);
                    n_turn    = 1'b1;
                    n_adc     = r_adc_enable;
                end else begin
                    n_counter = CB'(count_inc);
                end
            end else begin
                if (r_counter <= CB'(1)) begin
                    n_counter = '0;
                    n_turn    = 1'b1;
                end else begin
                    n_counter = r_counter - 1'b1;
                end
            end
            if (n_turn) begin
                n_dir_down = !r_dir_down;
                for (int k = 0; k < NPH; k++) begin
                    n_active[k] = r_preload[k];
                end
            end
        end
    end

    // Phase levels: count < floor(prod / FS) iff (count + 1) * FS <= prod,
    // except at the counter's top value, where the compare saturates.
    always_comb begin
        count_scaled = CMPW'({1'b0, n_counter} + 1'b1) * CMPW'(FS);
        for (int k = 0; k < NPH; k++) begin
            n_pwm[k] = (n_counter != CNT_MAX) && (count_scaled <= CMPW'(n_active[k]));
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_top   <= tpwm_pkg::PERIOD_W'(1000);
            r_duty_floor   <= '0;
            r_duty_ceiling <= tpwm_pkg::DUTY_CFG_W'(1000);
            r_adc_enable   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (tpwm_pkg::t_cfg_idx'(i_cfg_index))
                tpwm_pkg::CFG_PERIOD_TOP:   r_period_top   <= i_cfg_data;
                tpwm_pkg::CFG_DUTY_FLOOR:   r_duty_floor   <= i_cfg_data[tpwm_pkg::DUTY_CFG_W-1:0];
                tpwm_pkg::CFG_DUTY_CEILING: r_duty_ceiling <= i_cfg_data[tpwm_pkg::DUTY_CFG_W-1:0];
                tpwm_pkg::CFG_ADC_ENABLE:   r_adc_enable   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Timer state update on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter  <= '0;
            r_dir_down <= 1'b0;
            for (int k = 0; k < NPH; k++) begin
                r_preload[k] <= '0;
                r_active[k]  <= '0;
            end
        end else if (in_accept) begin
            r_counter  <= n_counter;
            r_dir_down <= n_dir_down;
            for (int k = 0; k < NPH; k++) begin
                r_active[k] <= n_active[k];
                if (!op_is_tick(i_op)) begin
                    r_preload[k] <= n_preload[k];
                end
            end
        end
    end

    // Output register: loads on acceptance, empties when the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pwm   <= n_pwm;
            r_adc   <= n_adc;
            r_upd   <= n_turn;
            r_count <= tpwm_pkg::COUNT_W'(n_counter);
            r_down  <= n_dir_down;
        end
    end

    assign o_valid         = r_valid;
    assign o_pwm_a         = r_pwm[0];
    assign o_pwm_b         = r_pwm[1];
    assign o_pwm_c         = r_pwm[2];
    assign o_adc_trigger   = r_adc;
    assign o_update_event  = r_upd;
    assign o_count_value   = r_count;
    assign o_counting_down = r_down;

`ifndef ASSERT_OFF
    // An ADC trigger only comes with a peak turn, after which the count runs down.
    a_adc_at_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_adc_trigger |-> o_update_event && o_counting_down)
        else $error("ADC trigger without a peak turn");

    // A valley turn leaves the counter at zero.
    a_valley_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_update_event && !o_counting_down |-> o_count_value == '0)
        else $error("valley turn with nonzero count");

    // Every turn flips the counting direction.
    a_turn_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && n_turn |=> r_dir_down != $past(r_dir_down))
        else $error("turn did not flip direction");

    // A duty-set request leaves the counter and direction alone.
    a_set_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !op_is_tick(i_op) |=>
            $stable(r_counter) && $stable(r_dir_down))
        else $error("duty-set request moved the counter");
`endif

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the three-phase center-aligned PWM timer.
// Drives requests and register writes, predicts every result and checks it.
// Depends on tpwm_pkg and three_phase_center_aligned_pwm.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COUNTER_BITS    = tpwm_pkg::COUNTER_BITS;
    localparam int unsigned DUTY_FULL_SCALE = tpwm_pkg::DUTY_FULL_SCALE;
    localparam int unsigned PERIOD_MIN      = tpwm_pkg::PERIOD_MIN;
    localparam int unsigned NUM_PHASES      = tpwm_pkg::NUM_PHASES;
    localparam int unsigned DUTY_REQ_W      = tpwm_pkg::DUTY_REQ_W;
    localparam int unsigned PERIOD_W        = tpwm_pkg::PERIOD_W;
    localparam int unsigned DUTY_CFG_W      = tpwm_pkg::DUTY_CFG_W;
    localparam int unsigned COUNT_W         = tpwm_pkg::COUNT_W;
    localparam int unsigned CFG_IDX_W       = tpwm_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W      = tpwm_pkg::CFG_DATA_W;

    localparam int unsigned COUNT_MAX      = (1 << COUNTER_BITS) - 1;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned MAX_REPORTS    = 10;

    // One result as the block presents it.
    typedef struct packed {
        logic               pwm_a;
        logic               pwm_b;
        logic               pwm_c;
        logic               adc_trigger;
        logic               update_event;
        logic [COUNT_W-1:0] count_value;
        logic               counting_down;
    } t_pwm_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_op;
    logic [DUTY_REQ_W-1:0] i_duty_a;
    logic [DUTY_REQ_W-1:0] i_duty_b;
    logic [DUTY_REQ_W-1:0] i_duty_c;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_pwm_a;
    logic                  o_pwm_b;
    logic                  o_pwm_c;
    logic                  o_adc_trigger;
    logic                  o_update_event;
    logic [COUNT_W-1:0]    o_count_value;
    logic                  o_counting_down;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    three_phase_center_aligned_pwm uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_duty_a        (i_duty_a),
        .i_duty_b        (i_duty_b),
        .i_duty_c        (i_duty_c),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pwm_a         (o_pwm_a),
        .o_pwm_b         (o_pwm_b),
        .o_pwm_c         (o_pwm_c),
        .o_adc_trigger   (o_adc_trigger),
        .o_update_event  (o_update_event),
        .o_count_value   (o_count_value),
        .o_counting_down (o_counting_down),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Shadow copy of the registers and of the timer state.
    logic [PERIOD_W-1:0]   cfg_period_top;
    logic [DUTY_CFG_W-1:0] cfg_duty_floor;
    logic [DUTY_CFG_W-1:0] cfg_duty_ceiling;
    logic                  cfg_adc_enable;
    logic [COUNT_W-1:0]    timer_count;
    logic                  timer_down;
    logic [COUNT_W-1:0]    preload_cmp [NUM_PHASES];
    logic [COUNT_W-1:0]    active_cmp  [NUM_PHASES];

    t_pwm_result expected_results [$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned stuck_cycles;
    int unsigned errors;
    int unsigned requests_done;
    int unsigned duty_sets_done;
    int unsigned results_done;
    int unsigned config_writes;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Counter peak after the lower and upper limits are applied.
    function automatic int unsigned effective_peak();
        int unsigned p;
        p = 32'(cfg_period_top);
        if (p < PERIOD_MIN) p = PERIOD_MIN;
        if (p > COUNT_MAX) p = COUNT_MAX;
        return p;
    endfunction

    // Clamp one duty request and scale it to a compare value.
    function automatic logic [COUNT_W-1:0] duty_to_compare(input logic [DUTY_REQ_W-1:0] req);
        int unsigned d;
        int unsigned c;
        d = 32'(req);
        if (d > DUTY_FULL_SCALE) d = DUTY_FULL_SCALE;
        if (d != 0) begin
            if (d < cfg_duty_floor) begin
                d = 32'(cfg_duty_floor);
            end else if (d > cfg_duty_ceiling) begin
                d = 32'(cfg_duty_ceiling);
            end
        end
        c = (d * effective_peak()) / DUTY_FULL_SCALE;
        if (c > COUNT_MAX) c = COUNT_MAX;
        return c[COUNT_W-1:0];
    endfunction

    // Advance the shadow timer by one request and work out its result.
    task automatic step_timer(input logic op, input logic [DUTY_REQ_W-1:0] a,
                              input logic [DUTY_REQ_W-1:0] b,
                              input logic [DUTY_REQ_W-1:0] c,
                              output t_pwm_result res);
        int unsigned p;
        int unsigned cnt;
        logic        turn;
        logic        adc;
        turn = 1'b0;
        adc  = 1'b0;
        if (op == tpwm_pkg::OP_SET_DUTY) begin
            preload_cmp[0] = duty_to_compare(a);
            preload_cmp[1] = duty_to_compare(b);
            preload_cmp[2] = duty_to_compare(c);
        end else begin
            p   = effective_peak();
            cnt = 32'(timer_count);
            if (!timer_down) begin
                // A lowered peak below the count turns the counter at once.
                if (cnt + 1 >= p) begin
                    cnt  = p;
                    turn = 1'b1;
                    adc  = cfg_adc_enable;
                end else begin
                    cnt = cnt + 1;
                end
            end else begin
                if (cnt <= 1) begin
                    cnt  = 0;
                    turn = 1'b1;
                end else begin
                    cnt = cnt - 1;
                end
            end
            timer_count = cnt[COUNT_W-1:0];
            if (turn) begin
                timer_down = ~timer_down;
                for (int i = 0; i < NUM_PHASES; i++) active_cmp[i] = preload_cmp[i];
            end
        end
        res.pwm_a         = timer_count < active_cmp[0];
        res.pwm_b         = timer_count < active_cmp[1];
        res.pwm_c         = timer_count < active_cmp[2];
        res.adc_trigger   = adc;
        res.update_event  = turn;
        res.count_value   = timer_count;
        res.counting_down = timer_down;
    endtask

    // Check each accepted result, then predict each accepted request.
    always @(posedge i_clk) begin : monitor
        t_pwm_result got;
        t_pwm_result want;
        logic        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                results_done++;
                got = {o_pwm_a, o_pwm_b, o_pwm_c, o_adc_trigger, o_update_event,
                       o_count_value, o_counting_down};
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected result: pwm=%b%b%b adc=%b upd=%b",
                                 got.pwm_a, got.pwm_b, got.pwm_c, got.adc_trigger,
                                 got.update_event, " count=%0d down=%b",
                                 got.count_value, got.counting_down);
                end else begin
                    want = expected_results.pop_front();
                    if (got.pwm_a !== want.pwm_a || got.pwm_b !== want.pwm_b ||
                        got.pwm_c !== want.pwm_c || got.adc_trigger !== want.adc_trigger ||
                        got.update_event !== want.update_event ||
                        got.count_value !== want.count_value ||
                        got.counting_down !== want.counting_down) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("result %0d expected: pwm=%b%b%b adc=%b upd=%b",
                                     results_done, want.pwm_a, want.pwm_b, want.pwm_c,
                                     want.adc_trigger, want.update_event,
                                     " count=%0d down=%b",
                                     want.count_value, want.counting_down);
                            $display("result %0d actual:   pwm=%b%b%b adc=%b upd=%b",
                                     results_done, got.pwm_a, got.pwm_b, got.pwm_c,
                                     got.adc_trigger, got.update_event,
                                     " count=%0d down=%b",
                                     got.count_value, got.counting_down);
                        end
                    end
                end
            end
            if (i_valid && !o_stall) begin
                moved = 1'b1;
                requests_done++;
                if (i_op == tpwm_pkg::OP_SET_DUTY) duty_sets_done++;
                step_timer(i_op, i_duty_a, i_duty_b, i_duty_c, want);
                expected_results.push_back(want);
            end
            if (i_cfg_valid && o_cfg_ready) moved = 1'b1;
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
        end
    end

    // The receiver stalls at random, at the rate the current phase sets.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    // End the run when nothing has been accepted for too long.
    initial begin
        stuck_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (stuck_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Present one request, with random idle cycles ahead, until it is taken.
    task automatic send_request(input tpwm_pkg::t_op op, input logic [DUTY_REQ_W-1:0] a,
                                input logic [DUTY_REQ_W-1:0] b,
                                input logic [DUTY_REQ_W-1:0] c);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_op     = op;
        i_duty_a = a;
        i_duty_b = b;
        i_duty_c = c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_request(tpwm_pkg::OP_TICK, DUTY_REQ_W'($urandom),
                                DUTY_REQ_W'($urandom), DUTY_REQ_W'($urandom));
    endtask

    // Write one register and mirror it in the shadow copy.
    task automatic write_config(input tpwm_pkg::t_cfg_idx idx,
                                input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            tpwm_pkg::CFG_PERIOD_TOP:   cfg_period_top   = data[PERIOD_W-1:0];
            tpwm_pkg::CFG_DUTY_FLOOR:   cfg_duty_floor   = data[DUTY_CFG_W-1:0];
            tpwm_pkg::CFG_DUTY_CEILING: cfg_duty_ceiling = data[DUTY_CFG_W-1:0];
            tpwm_pkg::CFG_ADC_ENABLE:   cfg_adc_enable   = data[0];
            default: ;
        endcase
        config_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Duty requests that favor full scale, zero and the clamp limits.
    function automatic logic [DUTY_REQ_W-1:0] pick_duty();
        logic [DUTY_REQ_W-1:0] d;
        case ($urandom_range(0, 7))
            0:       d = '0;
            1:       d = DUTY_REQ_W'(DUTY_FULL_SCALE);
            2:       d = '1;
            3, 4:    d = DUTY_REQ_W'($urandom);
            5:       d = DUTY_REQ_W'(cfg_duty_floor + $urandom_range(0, 2) - 1);
            6:       d = DUTY_REQ_W'(cfg_duty_ceiling + $urandom_range(0, 2) - 1);
            default: d = DUTY_REQ_W'($urandom_range(0, DUTY_FULL_SCALE));
        endcase
        return d;
    endfunction

    // New register settings; short peaks dominate so that turns are frequent.
    task automatic randomize_settings();
        logic [CFG_DATA_W-1:0] period;
        int unsigned           sel;
        int unsigned           value;
        sel = $urandom_range(0, 3);
        case ($urandom_range(0, 9))
            0:       period = (sel == 3) ? 16'hFFFF : CFG_DATA_W'(sel);
            1:       period = CFG_DATA_W'($urandom);
            default: period = CFG_DATA_W'($urandom_range(2, 40));
        endcase
        write_config(tpwm_pkg::CFG_PERIOD_TOP, period);
        if ($urandom_range(0, 1)) begin
            value = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 150);
            write_config(tpwm_pkg::CFG_DUTY_FLOOR, {6'($urandom), 10'(value)});
        end
        if ($urandom_range(0, 1)) begin
            value = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(600, 1000);
            write_config(tpwm_pkg::CFG_DUTY_CEILING, {6'($urandom), 10'(value)});
        end
        write_config(tpwm_pkg::CFG_ADC_ENABLE, {15'($urandom), 1'($urandom)});
    endtask

    // Smallest peak, ADC pulses at the peak, and duty extremes.
    task automatic test_short_peak_and_adc();
        write_config(tpwm_pkg::CFG_PERIOD_TOP, 16'd1);
        write_config(tpwm_pkg::CFG_ADC_ENABLE, 16'd1);
        write_config(tpwm_pkg::CFG_DUTY_FLOOR, 16'd0);
        write_config(tpwm_pkg::CFG_DUTY_CEILING, 16'd1000);
        send_request(tpwm_pkg::OP_SET_DUTY, 16'd1000, 16'd500, 16'd0);
        send_ticks(5);
        send_request(tpwm_pkg::OP_SET_DUTY, 16'hFFFF, 16'd1, 16'd999);
        send_ticks(2);
        wait_for_drain();
    endtask

    // A floor above the ceiling wins for small duties.
    task automatic test_floor_above_ceiling();
        write_config(tpwm_pkg::CFG_PERIOD_TOP, 16'd10);
        write_config(tpwm_pkg::CFG_DUTY_FLOOR, 16'd300);
        write_config(tpwm_pkg::CFG_DUTY_CEILING, 16'd200);
        send_request(tpwm_pkg::OP_SET_DUTY, 16'd100, 16'd1000, 16'd0);
        send_ticks(6);
        wait_for_drain();
    endtask

    // Compares saturate at the counter limit; a lowered peak turns the counter.
    task automatic test_peak_lowered_and_saturation();
        write_config(tpwm_pkg::CFG_PERIOD_TOP, 16'hFFFF);
        write_config(tpwm_pkg::CFG_DUTY_FLOOR, 16'd1023);
        write_config(tpwm_pkg::CFG_DUTY_CEILING, 16'd0);
        write_config(tpwm_pkg::CFG_ADC_ENABLE, 16'd0);
        send_request(tpwm_pkg::OP_SET_DUTY, 16'd1, 16'hFFFF, 16'd0);
        wait_for_drain();
        write_config(tpwm_pkg::CFG_PERIOD_TOP, 16'd3);
        send_ticks(4);
        wait_for_drain();
    endtask

    // Random requests in segments, each with its own register settings.
    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                       input int unsigned n_items);
        int unsigned sent;
        int unsigned seg_len;
        sent          = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (sent < n_items) begin
            wait_for_drain();
            randomize_settings();
            seg_len = $urandom_range(60, 140);
            repeat (seg_len) begin
                if ($urandom_range(99) < 70) begin
                    send_request(tpwm_pkg::OP_TICK, pick_duty(), pick_duty(), pick_duty());
                end else begin
                    send_request(tpwm_pkg::OP_SET_DUTY, pick_duty(), pick_duty(),
                                 pick_duty());
                end
            end
            sent += seg_len;
        end
        wait_for_drain();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_op             = tpwm_pkg::OP_TICK;
        i_duty_a         = '0;
        i_duty_b         = '0;
        i_duty_c         = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = tpwm_pkg::CFG_PERIOD_TOP;
        i_cfg_data       = '0;
        send_idle_pct    = 25;
        recv_idle_pct    = 78;
        errors           = 0;
        requests_done    = 0;
        duty_sets_done   = 0;
        results_done     = 0;
        config_writes    = 0;
        cfg_period_top   = 16'd1000;
        cfg_duty_floor   = '0;
        cfg_duty_ceiling = 10'd1000;
        cfg_adc_enable   = 1'b0;
        timer_count      = '0;
        timer_down       = 1'b0;
        for (int i = 0; i < NUM_PHASES; i++) begin
            preload_cmp[i] = '0;
            active_cmp[i]  = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_short_peak_and_adc();
        test_floor_above_ceiling();
        test_peak_lowered_and_saturation();
        test_random_traffic(25, 78, 630);
        test_random_traffic(78, 25, 630);
        test_random_traffic(0, 0, 630);

        if (expected_results.size() != 0) begin
            errors++;
            $display("%0d expected results never arrived", expected_results.size());
        end
        $display("run covered %0d requests (%0d duty sets), %0d results, %0d register writes",
                 requests_done, duty_sets_done, results_done, config_writes);
        $display("with peaks from the minimum to the counter limit; %0d mismatches", errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
